FILE: hw/rtl/dcf_pkg.sv
// Shared types and constants for the directed cycle finder.
// Depends on nothing; every other file imports it.
`default_nettype none

package dcf_pkg;

    localparam int NV      = 64;
    localparam int NE      = 256;
    localparam int VW      = 6;
    localparam int EW      = 8;
    localparam int PW      = EW + 1;
    localparam int CW      = 7;

    typedef struct packed {
        logic          edge_valid;
        logic [VW-1:0] edge_source;
        logic [VW-1:0] edge_target;
        logic          last_edge;
    } in_item_t;

    typedef struct packed {
        logic          cycle_found;
        logic [CW-1:0] cycle_length;
        logic [EW-1:0] edge_index;
        logic          overflow;
        logic          last_result;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_ROOT, ST_ROOT_LD, ST_STEP, ST_POP, ST_EDGE, ST_CHILD,
        ST_PATH, ST_PATH_LD, ST_EMIT_RD, ST_EMIT_HEAD, ST_SCAN_INIT, ST_SCAN,
        ST_SCAN_CHK, ST_OUT, ST_NONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic ld_store;
        logic srch_init;
        logic root_next;
        logic root_open;
        logic root_load;
        logic pop;
        logic pop_load;
        logic edge_eval;
        logic child_load;
        logic path_write;
        logic path_load;
        logic emit_head;
        logic scan_init;
        logic scan_rd;
        logic scan_zero;
        logic scan_chk;
        logic out_cycle;
        logic out_none;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        logic cur_edge;
        logic cur_last;
        logic item_last;
        logic root_end;
        logic root_white;
        logic top_none;
        logic depth_one;
        logic t_white;
        logic t_grey;
        logic path_end;
        logic scan_none;
        logic scan_hit;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dcf_ctrl.sv
// Sequencer of the cycle finder: loads edges, runs the walk, emits the answer.
// Depends on dcf_pkg; drives dcf_dp through cmd_t and reads stat_t.
`default_nettype none

module dcf_ctrl
    import dcf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.cur_edge)
                        state_next = ST_LOAD;
                    else if (stat.cur_last)
                        state_next = ST_ROOT;
                end
            end
            ST_LOAD:      state_next = stat.item_last ? ST_ROOT : ST_IDLE;
            ST_ROOT:
            begin
                if (stat.root_end)
                    state_next = ST_NONE;
                else if (stat.root_white)
                    state_next = ST_ROOT_LD;
            end
            ST_ROOT_LD:   state_next = ST_STEP;
            ST_STEP:
            begin
                if (!stat.top_none)
                    state_next = ST_EDGE;
                else if (stat.depth_one)
                    state_next = ST_ROOT;
                else
                    state_next = ST_POP;
            end
            ST_POP:       state_next = ST_STEP;
            ST_EDGE:
            begin
                if (stat.t_white)
                    state_next = ST_CHILD;
                else if (stat.t_grey)
                    state_next = ST_PATH;
                else
                    state_next = ST_STEP;
            end
            ST_CHILD:     state_next = ST_STEP;
            ST_PATH:      state_next = stat.path_end ? ST_EMIT_RD : ST_PATH_LD;
            ST_PATH_LD:   state_next = ST_PATH;
            ST_EMIT_RD:   state_next = ST_EMIT_HEAD;
            ST_EMIT_HEAD: state_next = ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = ST_SCAN;
            ST_SCAN:      state_next = stat.scan_none ? ST_OUT : ST_SCAN_CHK;
            ST_SCAN_CHK:  state_next = stat.scan_hit ? ST_OUT : ST_SCAN;
            ST_OUT:
            begin
                if (stat.out_free)
                    state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            ST_NONE:      state_next = stat.out_free ? ST_IDLE : ST_NONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.accept     = in_valid;
                cmd.srch_init  = in_valid && !stat.cur_edge && stat.cur_last;
            end
            ST_LOAD:
            begin
                cmd.ld_store  = 1'b1;
                cmd.srch_init = stat.item_last;
            end
            ST_ROOT:
            begin
                cmd.root_open = !stat.root_end && stat.root_white;
                cmd.root_next = !stat.root_end && !stat.root_white;
            end
            ST_ROOT_LD:   cmd.root_load = 1'b1;
            ST_STEP:
            begin
                cmd.pop       = stat.top_none;
                cmd.root_next = stat.top_none && stat.depth_one;
            end
            ST_POP:       cmd.pop_load = 1'b1;
            ST_EDGE:      cmd.edge_eval = 1'b1;
            ST_CHILD:     cmd.child_load = 1'b1;
            ST_PATH:      cmd.path_write = 1'b1;
            ST_PATH_LD:   cmd.path_load = 1'b1;
            ST_EMIT_RD:   cmd = '0;
            ST_EMIT_HEAD: cmd.emit_head = 1'b1;
            ST_SCAN_INIT: cmd.scan_init = 1'b1;
            ST_SCAN:
            begin
                cmd.scan_rd   = !stat.scan_none;
                cmd.scan_zero = stat.scan_none;
            end
            ST_SCAN_CHK:  cmd.scan_chk = 1'b1;
            ST_OUT:
            begin
                cmd.out_cycle = stat.out_free;
                cmd.emit_next = stat.out_free && !stat.emit_last;
            end
            ST_NONE:      cmd.out_none = stat.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dcf_dp.sv
// Datapath of the cycle finder: edge lists, marks, walk stack, path and output item.
// Depends on dcf_pkg; commanded by dcf_ctrl.
`default_nettype none

module dcf_dp
    import dcf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_item,
    input  wire logic      out_ready,
    output logic           out_valid,
    output out_item_t      out_item,
    input  wire logic      cfg_we,
    input  wire logic [CW-1:0] cfg_data,
    input  wire cmd_t      cmd,
    output stat_t          stat
);

    // memories, no reset
    logic [VW-1:0]    tgt_mem  [NE];
    logic [EW-1:0]    nxt_mem  [NE];
    logic [EW-1:0]    head_mem [NV];
    logic [EW-1:0]    tail_mem [NV];
    logic [VW-1:0]    par_mem  [NV];
    logic [VW+PW-1:0] stk_mem  [NV];
    logic [VW-1:0]    raw_mem  [NV];

    // control state
    logic [CW-1:0] vcount_reg;
    logic [EW:0]   total_reg;
    logic          ovf_reg;
    logic [NV-1:0] lv_reg, grey_reg, black_reg;
    logic [NE-1:0] nv_reg;
    logic [CW-1:0] root_reg, depth_reg, n_reg, i_reg;
    logic          out_valid_reg;

    // payload registers
    in_item_t      item_reg;
    out_item_t     out_reg;
    logic [EW-1:0] tail_rd_reg, head_rd_reg, nxt_rd_reg;
    logic          hv_reg, nvs_reg;
    logic [VW-1:0] tgt_rd_reg, par_rd_reg, raw_a_reg, raw_b_reg;
    logic [VW+PW-1:0] stk_rd_reg;
    logic [VW-1:0] top_v_reg, t_reg, cyc_head_reg, pv_reg, b_reg;
    logic [PW-1:0] top_e_reg, se_reg;
    logic [EW-1:0] idx_reg;

    logic [PW-1:0] hp, np;
    logic [VW-1:0] head_addr, edge_src;
    logic [EW-1:0] edge_addr, new_e;
    logic [CW-1:0] roots, raw_a_idx, raw_b_idx, depth_m1, depth_m2;
    logic          t_white, t_grey, do_clear, out_free;

    assign hp        = {~hv_reg, head_rd_reg};
    assign np        = {~nvs_reg, nxt_rd_reg};
    assign edge_src  = item_reg.edge_source;
    assign new_e     = total_reg[EW-1:0];
    assign roots     = (vcount_reg > CW'(NV)) ? CW'(NV) : vcount_reg;
    assign depth_m1  = depth_reg - CW'(1);
    assign depth_m2  = depth_reg - CW'(2);
    assign raw_a_idx = n_reg - i_reg - CW'(1);
    assign raw_b_idx = n_reg - i_reg - CW'(2);
    assign t_white   = !grey_reg[tgt_rd_reg] && !black_reg[tgt_rd_reg];
    assign t_grey    = grey_reg[tgt_rd_reg] && !black_reg[tgt_rd_reg];
    assign out_free  = !out_valid_reg || out_ready;
    assign do_clear  = (cmd.out_cycle && stat.emit_last) || cmd.out_none;
    assign edge_addr = cmd.scan_rd ? se_reg[EW-1:0] : top_e_reg[EW-1:0];

    always_comb
    begin
        if (cmd.root_open)
            head_addr = root_reg[VW-1:0];
        else if (cmd.edge_eval)
            head_addr = tgt_rd_reg;
        else
            head_addr = raw_a_reg;
    end

    always_comb
    begin
        stat.cur_edge   = in_item.edge_valid;
        stat.cur_last   = in_item.last_edge;
        stat.item_last  = item_reg.last_edge;
        stat.root_end   = root_reg >= roots;
        stat.root_white = !grey_reg[root_reg[VW-1:0]] && !black_reg[root_reg[VW-1:0]];
        stat.top_none   = top_e_reg[PW-1];
        stat.depth_one  = depth_reg == CW'(1);
        stat.t_white    = t_white;
        stat.t_grey     = t_grey;
        stat.path_end   = (pv_reg == cyc_head_reg) || (n_reg == CW'(NV - 1));
        stat.scan_none  = se_reg[PW-1];
        stat.scan_hit   = tgt_rd_reg == b_reg;
        stat.emit_last  = i_reg == (n_reg - CW'(1));
        stat.out_free   = out_free;
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        tail_rd_reg <= tail_mem[in_item.edge_source];
        if (cmd.ld_store && !total_reg[EW])
            tail_mem[edge_src] <= new_e;
    end

    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_mem[head_addr];
        hv_reg      <= lv_reg[head_addr];
        if (cmd.ld_store && !total_reg[EW] && !lv_reg[edge_src])
            head_mem[edge_src] <= new_e;
    end

    always_ff @(posedge clk)
    begin
        tgt_rd_reg <= tgt_mem[edge_addr];
        if (cmd.ld_store && !total_reg[EW])
            tgt_mem[new_e] <= item_reg.edge_target;
    end

    always_ff @(posedge clk)
    begin
        nxt_rd_reg <= nxt_mem[edge_addr];
        nvs_reg    <= nv_reg[edge_addr];
        if (cmd.ld_store && !total_reg[EW] && lv_reg[edge_src])
            nxt_mem[tail_rd_reg] <= new_e;
    end

    always_ff @(posedge clk)
    begin
        stk_rd_reg <= stk_mem[depth_m2[VW-1:0]];
        if (cmd.edge_eval && t_white)
            stk_mem[depth_m1[VW-1:0]] <= {top_v_reg, np};
    end

    always_ff @(posedge clk)
    begin
        par_rd_reg <= par_mem[pv_reg];
        if (cmd.edge_eval && t_white)
            par_mem[tgt_rd_reg] <= top_v_reg;
    end

    always_ff @(posedge clk)
    begin
        raw_a_reg <= raw_mem[raw_a_idx[VW-1:0]];
        raw_b_reg <= raw_mem[raw_b_idx[VW-1:0]];
        if (cmd.path_write)
            raw_mem[n_reg[VW-1:0]] <= pv_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= in_item;
        if (cmd.root_load)
        begin
            top_v_reg <= root_reg[VW-1:0];
            top_e_reg <= hp;
        end
        if (cmd.pop_load)
            {top_v_reg, top_e_reg} <= stk_rd_reg;
        if (cmd.edge_eval)
        begin
            top_e_reg <= np;
            t_reg     <= tgt_rd_reg;
            if (t_grey)
            begin
                cyc_head_reg <= tgt_rd_reg;
                pv_reg       <= top_v_reg;
            end
        end
        if (cmd.child_load)
        begin
            top_v_reg <= t_reg;
            top_e_reg <= hp;
        end
        if (cmd.path_load)
            pv_reg <= par_rd_reg;
        if (cmd.emit_head)
            b_reg <= stat.emit_last ? cyc_head_reg : raw_b_reg;
        if (cmd.scan_init)
            se_reg <= hp;
        if (cmd.scan_zero)
            idx_reg <= '0;
        if (cmd.scan_chk)
        begin
            if (stat.scan_hit)
                idx_reg <= se_reg[EW-1:0];
            else
                se_reg <= np;
        end
        if (cmd.out_cycle)
            out_reg <= '{cycle_found: 1'b1, cycle_length: n_reg, edge_index: idx_reg,
                         overflow: ovf_reg, last_result: stat.emit_last};
        if (cmd.out_none)
            out_reg <= '{cycle_found: 1'b0, cycle_length: '0, edge_index: '0,
                         overflow: ovf_reg, last_result: 1'b1};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= CW'(NV);
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            lv_reg        <= '0;
            nv_reg        <= '0;
            grey_reg      <= '0;
            black_reg     <= '0;
            root_reg      <= '0;
            depth_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                vcount_reg <= cfg_data;
            if (cmd.ld_store)
            begin
                if (total_reg[EW])
                    ovf_reg <= 1'b1;
                else
                begin
                    total_reg      <= total_reg + (EW+1)'(1);
                    lv_reg[edge_src] <= 1'b1;
                    nv_reg[new_e]  <= 1'b0;
                    if (lv_reg[edge_src])
                        nv_reg[tail_rd_reg] <= 1'b1;
                end
            end
            if (cmd.srch_init)
                root_reg <= '0;
            if (cmd.root_next)
                root_reg <= root_reg + CW'(1);
            if (cmd.root_open)
                grey_reg[root_reg[VW-1:0]] <= 1'b1;
            if (cmd.root_load)
                depth_reg <= CW'(1);
            if (cmd.pop)
            begin
                black_reg[top_v_reg] <= 1'b1;
                depth_reg            <= depth_m1;
            end
            if (cmd.edge_eval && t_white)
                grey_reg[tgt_rd_reg] <= 1'b1;
            if (cmd.edge_eval && t_grey)
                n_reg <= '0;
            if (cmd.child_load)
                depth_reg <= depth_reg + CW'(1);
            if (cmd.path_write)
            begin
                n_reg <= n_reg + CW'(1);
                i_reg <= '0;
            end
            if (cmd.emit_next)
                i_reg <= i_reg + CW'(1);
            if (cmd.out_cycle || cmd.out_none)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (do_clear)
            begin
                total_reg <= '0;
                ovf_reg   <= 1'b0;
                lv_reg    <= '0;
                grey_reg  <= '0;
                black_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/directed_cycle_finder.sv
// Directed cycle finder: depth-first three-color walk over a stored edge list.
// An edge item is accepted, then stored and linked into its source's list; no new
// item is taken meanwhile. The closing item runs the walk (follow an edge, push, pop,
// open a root), then the path trace vertex by vertex and, per result, the scan of the
// source's edge list for its index; a result waits while the output is stalled.
// Reset: asynchronous, active low; empties all stores, vertex_count returns to 64.
`default_nettype none

module directed_cycle_finder
    import dcf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item,
    input  wire logic      cfg_we,
    input  wire logic [CW-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Sequence the load, walk, path trace and item emission.
    dcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the graph, marks, stack and the output item register.
    dcf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
